// ===== rtl/core/audio_frame_header_sync_parser_top_assert.svh =====
`ifndef AUDIO_FRAME_HEADER_SYNC_PARSER_TOP_ASSERT_SVH
`define AUDIO_FRAME_HEADER_SYNC_PARSER_TOP_ASSERT_SVH

// invariant checked on every clock edge out of reset
`define AFHS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cause on one edge, effect on the next
`define AFHS_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

// ===== rtl/core/afhs_pkg.sv =====
package afhs_pkg;

    localparam logic [7:0]  SYNC_HI         = 8'h7F;
    localparam logic [7:0]  SYNC_LO         = 8'hFF;
    localparam logic [3:0]  MAX_RATE        = 4'd12;
    localparam logic [2:0]  HDR_BYTES       = 3'd6;
    localparam logic [14:0] HDR_BYTES_CNT   = 15'd6;
    localparam int          WIN_W           = 40;
    localparam int          OUT_DATA_W      = 48;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY,
        PH_CHECK
    } t_phase;

    typedef struct packed {
        logic        header_type;
        logic [14:0] frame_bytes;
        logic [3:0]  blocks_per_frame;
        logic [3:0]  rate_index;
        logic [6:0]  normal_channels;
        logic [1:0]  lfe_channels;
        logic        aux_config;
        logic        use_sum_diff;
        logic        use_joint_intensity;
        logic [5:0]  joint_bands;
    } t_hdr;

    typedef struct packed {
        logic valid;
        logic frame_ok;
        t_hdr hdr;
    } t_result;

endpackage

// ===== rtl/core/afhs_in_stage.sv =====
module afhs_in_stage
    import afhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    output logic       o_ready,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== rtl/core/afhs_parser.sv =====
`include "audio_frame_header_sync_parser_top_assert.svh"

module afhs_parser
    import afhs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase             r_phase, n_phase;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [2:0]         r_fill, n_fill;
    logic [14:0]        r_count, n_count;
    t_hdr               r_held, n_held;
    logic [7:0]         r_prev;

    logic [WIN_W-1:0]   w_shift;
    logic [2:0]         w_fill_inc;
    logic               w_full;
    t_hdr               w_hdr;
    logic               w_hdr_good;
    logic               w_resync;
    logic [2:0]         w_keep;
    logic               w_body_done;

    function automatic t_hdr decode_hdr(input logic [31:0] w);
        t_hdr h;
        h = '0;
        h.header_type = w[31];
        if (!w[31]) begin
            h.frame_bytes      = {3'b000, w[30:21], 2'b00};
            h.blocks_per_frame = 4'd1 << w[20:19];
            h.rate_index       = w[18:15];
            h.normal_channels  = {4'b0000, w[14:12]} + 7'd1;
            h.lfe_channels     = {1'b0, w[11]};
            h.aux_config       = w[10];
            if (w[14:12] != 3'd0) begin
                h.use_sum_diff        = w[9];
                h.use_joint_intensity = w[8];
                if (w[8]) begin
                    h.joint_bands = {1'b0, w[7:3]} + 6'd1;
                end
            end
        end else begin
            h.frame_bytes      = {w[30:18], 2'b00};
            h.blocks_per_frame = 4'd1 << w[17:16];
            h.rate_index       = w[15:12];
            h.normal_channels  = {1'b0, w[11:6]} + 7'd1;
            h.lfe_channels     = w[5:4];
            h.aux_config       = w[3];
        end
        return h;
    endfunction

    assign w_shift     = {r_win[WIN_W-9:0], i_byte};
    assign w_fill_inc  = (r_fill < HDR_BYTES) ? r_fill + 3'd1 : r_fill;
    assign w_full      = (w_fill_inc >= HDR_BYTES);
    assign w_hdr       = decode_hdr(w_shift[31:0]);
    assign w_hdr_good  = (w_hdr.rate_index <= MAX_RATE) && (w_hdr.frame_bytes >= HDR_BYTES_CNT);
    assign w_body_done = (r_count >= r_held.frame_bytes);

    // rescan bytes 1..5 of the rejected window for a sync pair, earliest first
    always_comb begin
        w_resync = 1'b1;
        if (w_shift[39:32] == SYNC_HI && w_shift[31:24] == SYNC_LO) begin
            w_keep = 3'd5;
        end else if (w_shift[31:24] == SYNC_HI && w_shift[23:16] == SYNC_LO) begin
            w_keep = 3'd4;
        end else if (w_shift[23:16] == SYNC_HI && w_shift[15:8] == SYNC_LO) begin
            w_keep = 3'd3;
        end else if (w_shift[15:8] == SYNC_HI && w_shift[7:0] == SYNC_LO) begin
            w_keep = 3'd2;
        end else begin
            w_keep   = 3'd0;
            w_resync = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_win   = r_win;
        n_fill  = r_fill;
        n_count = r_count;
        n_held  = r_held;
        case (r_phase)
            PH_HUNT: begin
                if (r_prev == SYNC_HI && i_byte == SYNC_LO) begin
                    n_phase = PH_HEADER;
                    n_win   = {{(WIN_W-16){1'b0}}, SYNC_HI, SYNC_LO};
                    n_fill  = 3'd2;
                end
            end
            PH_HEADER: begin
                n_win  = w_shift;
                n_fill = w_fill_inc;
                if (w_full) begin
                    if (w_hdr_good) begin
                        n_held  = w_hdr;
                        n_count = HDR_BYTES_CNT;
                        n_phase = PH_BODY;
                    end else if (w_resync) begin
                        n_fill = w_keep;
                    end else begin
                        n_fill  = 3'd0;
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_BODY: begin
                if (w_body_done) begin
                    n_phase = (i_byte == SYNC_HI) ? PH_CHECK : PH_HUNT;
                end else begin
                    n_count = r_count + 15'd1;
                end
            end
            PH_CHECK: begin
                if (i_byte == SYNC_LO) begin
                    n_phase = PH_HEADER;
                    n_win   = {{(WIN_W-16){1'b0}}, SYNC_HI, SYNC_LO};
                    n_fill  = 3'd2;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // result
    always_comb begin
        o_res = '0;
        case (r_phase)
            PH_HEADER: begin
                o_res.valid = i_fire && w_full && !w_hdr_good;
            end
            PH_BODY: begin
                o_res.valid = i_fire && w_body_done && (i_byte != SYNC_HI);
            end
            PH_CHECK: begin
                o_res.valid = i_fire;
                if (i_byte == SYNC_LO) begin
                    o_res.frame_ok = 1'b1;
                    o_res.hdr      = r_held;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_win   <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_prev  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_win   <= n_win;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_prev  <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held <= n_held;
        end
    end

    `AFHS_ASSERT_ALWAYS(a_fill_max, r_fill <= HDR_BYTES, "window fill above header size")
    `AFHS_ASSERT_ALWAYS(a_fill_header, (r_phase != PH_HEADER) || (r_fill >= 3'd2),
        "header collection without sync bytes")
    `AFHS_ASSERT_ALWAYS(a_count_bound, (r_phase != PH_BODY) || (r_count <= r_held.frame_bytes),
        "frame byte count ran past frame length")
    `AFHS_ASSERT_NEXT(a_good_restart, o_res.valid && o_res.frame_ok,
        r_phase == PH_HEADER && r_fill == 3'd2, "good frame did not restart header")

endmodule

// ===== rtl/core/afhs_out_stage.sv =====
module afhs_out_stage
    import afhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output logic    o_frame_ok,
    output t_hdr    o_hdr
);

    logic r_valid;
    logic r_frame_ok;
    t_hdr r_hdr;

    assign o_free     = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_frame_ok = r_frame_ok;
    assign o_hdr      = r_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_frame_ok <= i_res.frame_ok;
            r_hdr      <= i_res.hdr;
        end
    end

endmodule

// ===== rtl/core/audio_frame_header_sync_parser_top.sv =====
// channel   dir  tdata                         tuser
// s (byte)  in   [7:0] data_byte               -
// m (frame) out  header fields, see o_m_tdata  [0] frame_ok
//
// One byte per cycle sustained while the result is not stalled; each byte
// passes the input register, the parser state update and the result register.
// Synchronous active-low reset clears phase, window, fill, count and valids.
// A stalled result holds; the byte behind it waits in the input register.
// Bytes that end no frame decision produce no beat.
module audio_frame_header_sync_parser_top
    import afhs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,  // [7:0] data_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] header_type, [15:1] frame_bytes, [19:16] blocks_per_frame,
    // [23:20] rate_index, [30:24] normal_channels, [32:31] lfe_channels,
    // [33] aux_config, [34] use_sum_diff, [35] use_joint_intensity,
    // [41:36] joint_bands, [47:42] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser   // [0] frame_ok
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_free;
    logic       w_fire;
    t_result    w_res;
    t_hdr       w_hdr;

    assign w_fire = w_in_valid && w_out_free;

    afhs_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ready (o_s_tready),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_data  (w_in_byte)
    );

    afhs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (w_in_byte),
        .o_res   (w_res)
    );

    afhs_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_res      (w_res),
        .i_ready    (i_m_tready),
        .o_free     (w_out_free),
        .o_valid    (o_m_tvalid),
        .o_frame_ok (o_m_tuser),
        .o_hdr      (w_hdr)
    );

    assign o_m_tdata = {6'b000000,
                        w_hdr.joint_bands,
                        w_hdr.use_joint_intensity,
                        w_hdr.use_sum_diff,
                        w_hdr.aux_config,
                        w_hdr.lfe_channels,
                        w_hdr.normal_channels,
                        w_hdr.rate_index,
                        w_hdr.blocks_per_frame,
                        w_hdr.frame_bytes,
                        w_hdr.header_type};

endmodule
